@@ sv/joystick_event_conditioner_assert.svh @@
// assertion macros for the joystick event conditioner checker
`ifndef JOYSTICK_EVENT_CONDITIONER_ASSERT_SVH
`define JOYSTICK_EVENT_CONDITIONER_ASSERT_SVH

// same-cycle implication
`define JEC_ASSERT_NOW(lbl, ck, rs, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define JEC_ASSERT_NEXT(lbl, ck, rs, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) else $error(msg);

`endif

@@ sv/jec_pkg.sv @@
// shared constants and widths for the joystick event conditioner
`default_nettype none

package jec_pkg;

  localparam int MAX_BUTTONS_DEF = 16;
  localparam int MAX_AXES_DEF    = 8;

  localparam int EV_TYPE_W  = 8;
  localparam int EV_NUM_W   = 8;
  localparam int EV_VAL_W   = 16;
  localparam int AXIS_IDX_W = 3;
  localparam int AXIS_VAL_W = 16;
  localparam int BTN_BITS_W = 16;
  localparam int BTN_CNT_W  = 5;
  localparam int AXIS_CNT_W = 4;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 20;
  localparam int DZ_W       = 15;
  localparam int GAIN_W     = 20;
  localparam int TICKS_W    = 16;
  localparam int PROD_W     = AXIS_VAL_W + GAIN_W;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_STICKY = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DZ     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PERIOD = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ACCUM  = 3'd4;

  // register reset values
  localparam logic [DZ_W-1:0]    DZ_RST     = 15'd1638;
  localparam logic [GAIN_W-1:0]  GAIN_RST   = 20'd68985;
  localparam logic [TICKS_W-1:0] PERIOD_RST = 16'd1000;
  localparam logic [TICKS_W-1:0] ACCUM_RST  = 16'd1;

  // request and event kinds
  localparam logic REQ_EVENT = 1'b0;
  localparam logic REQ_TICK  = 1'b1;
  localparam logic [EV_TYPE_W-2:0] KIND_BUTTON = 7'd1;
  localparam logic [EV_TYPE_W-2:0] KIND_AXIS   = 7'd2;

  localparam logic [AXIS_VAL_W-1:0] Q15_MAX = 16'd32767;
  localparam logic [PROD_W-1:0]     ROUND_HALF = 36'd32768;

endpackage

`default_nettype wire

@@ sv/jec_if.sv @@
// valid/ready channel interfaces for events, results and configuration
`default_nettype none

interface jec_in_if;
  import jec_pkg::*;
  logic                        valid;
  logic                        ready;
  logic                        req_type;
  logic [EV_TYPE_W-1:0]        event_type;
  logic [EV_NUM_W-1:0]         event_number;
  logic signed [EV_VAL_W-1:0]  event_value;
  modport source (output valid, req_type, event_type, event_number, event_value,
                  input ready);
  modport sink (input valid, req_type, event_type, event_number, event_value,
                output ready);
endinterface

interface jec_out_if;
  import jec_pkg::*;
  logic                          valid;
  logic                          ready;
  logic [AXIS_IDX_W-1:0]         axis_index;
  logic signed [AXIS_VAL_W-1:0]  axis_value;
  logic [BTN_BITS_W-1:0]         button_bits;
  logic [BTN_CNT_W-1:0]          button_count;
  logic [AXIS_CNT_W-1:0]         axis_count;
  logic                          last;
  modport source (output valid, axis_index, axis_value, button_bits, button_count,
                  axis_count, last, input ready);
  modport sink (input valid, axis_index, axis_value, button_bits, button_count,
                axis_count, last, output ready);
endinterface

interface jec_cfg_if;
  import jec_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

@@ sv/joystick_event_conditioner.sv @@
// joystick event conditioner: button/axis state, deadzone and gain, timed publish
// Channels: events (sink) takes joystick events and time ticks, results (source)
// gives one beat per seen axis on each publish, cfg (sink) writes the five
// registers and is always ready.
// Steps: a tick or a button/unknown event is handled in the idle state unless it
// starts a publish. An axis event passes through accept, deadzone, 16x20 multiply
// and round/saturate with the axis memory write.
// A publish has a setup state and then a read and a load state per result beat,
// since the axis memory read is registered; up to eight beats, the last
// with last set. With no axes seen a publish gives a single beat with axis 0.
// events.ready is high only between items; the last result beat sits in the
// output register while the next item is taken.
// Stall: a stalled result beat holds its payload and the publish waits on it.
// Reset: registers return to their defaults, button state and counts clear,
// the countdown loads the default publish period and every axis entry reads
// zero until written (one valid flag per entry, no clearing pass).
`default_nettype none

module joystick_event_conditioner #(
  parameter int MAX_BUTTONS = jec_pkg::MAX_BUTTONS_DEF,
  parameter int MAX_AXES    = jec_pkg::MAX_AXES_DEF
) (
  input wire         clk,
  input wire         rst,
  jec_cfg_if.sink    cfg,
  jec_in_if.sink     events,
  jec_out_if.source  results
);
  import jec_pkg::*;

  localparam int BCW = $clog2(MAX_BUTTONS + 1);
  localparam int ACW = $clog2(MAX_AXES + 1);
  localparam int AW  = (MAX_AXES > 1) ? $clog2(MAX_AXES) : 1;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_CALC = 3'd1;
  localparam logic [2:0] S_MUL  = 3'd2;
  localparam logic [2:0] S_WR   = 3'd3;
  localparam logic [2:0] S_PUB  = 3'd4;
  localparam logic [2:0] S_RD   = 3'd5;
  localparam logic [2:0] S_LD   = 3'd6;

  logic [2:0] state;

  // configuration
  logic               sticky;
  logic [DZ_W-1:0]    dz;
  logic [GAIN_W-1:0]  gain;
  logic [TICKS_W-1:0] period;
  logic [TICKS_W-1:0] accum;

  // control state
  logic [MAX_BUTTONS-1:0] live;
  logic [MAX_BUTTONS-1:0] prev;
  logic [MAX_BUTTONS-1:0] tog;
  logic [BCW-1:0]         btn_seen;
  logic [ACW-1:0]         ax_seen;
  logic [TICKS_W-1:0]     countdown;
  logic                   gpend;
  logic                   gath;

  // axis datapath
  logic [AW-1:0]               ev_idx;
  logic signed [EV_VAL_W-1:0]  ev_val;
  logic [AXIS_VAL_W-1:0]       mag;
  logic                        neg;
  logic [PROD_W-1:0]           prod;

  // axis memory
  logic [AXIS_VAL_W-1:0] mem [MAX_AXES];
  logic [MAX_AXES-1:0]   vld;
  logic [AXIS_VAL_W-1:0] rd_data;
  logic                  rd_vld;

  // publish
  logic [ACW-1:0]         k;
  logic [MAX_BUTTONS-1:0] pub_bits;

  // output register
  logic                          out_valid;
  logic [AXIS_IDX_W-1:0]         out_idx;
  logic [AXIS_VAL_W-1:0]         out_val;
  logic [BTN_BITS_W-1:0]         out_bits;
  logic [BTN_CNT_W-1:0]          out_bcnt;
  logic [AXIS_CNT_W-1:0]         out_acnt;
  logic                          out_last;

  // decode of the incoming beat
  logic                   in_acc;
  logic [EV_TYPE_W-2:0]   kind;
  logic                   is_btn;
  logic                   is_axis;
  logic                   gp_next;
  logic [MAX_BUTTONS-1:0] live_next;
  logic                   btn_grow;
  logic                   ax_grow;

  always_comb begin
    in_acc  = events.valid && (state == S_IDLE);
    kind    = events.event_type[EV_TYPE_W-2:0];
    is_btn  = (events.req_type == REQ_EVENT) && (kind == KIND_BUTTON)
              && (events.event_number < EV_NUM_W'(MAX_BUTTONS));
    is_axis = (events.req_type == REQ_EVENT) && (kind == KIND_AXIS)
              && (events.event_number < EV_NUM_W'(MAX_AXES));
    if (is_btn) begin
      gp_next = !events.event_type[EV_TYPE_W-1];
    end else if (is_axis) begin
      gp_next = 1'b1;
    end else begin
      gp_next = gpend;
    end
    for (int i = 0; i < MAX_BUTTONS; i++) begin
      live_next[i] = (is_btn && events.event_number == EV_NUM_W'(i))
                     ? (events.event_value != '0) : live[i];
    end
    btn_grow = (9'(events.event_number) + 9'd1) > 9'(btn_seen);
    ax_grow  = (9'(events.event_number) + 9'd1) > 9'(ax_seen);
  end

  // deadzone removal: magnitude and sign of the reduced value
  logic signed [EV_VAL_W:0] v_s;
  logic signed [EV_VAL_W:0] dz_s;
  logic [AXIS_VAL_W-1:0]    mag_c;
  logic                     neg_c;

  always_comb begin
    v_s  = (EV_VAL_W + 1)'(ev_val);
    dz_s = $signed({2'b00, dz});
    neg_c = v_s > dz_s;
    if (v_s < -dz_s) begin
      mag_c = AXIS_VAL_W'(-v_s - dz_s);
    end else if (neg_c) begin
      mag_c = AXIS_VAL_W'(v_s - dz_s);
    end else begin
      mag_c = '0;
    end
  end

  // rounding, saturation and negation
  logic [PROD_W-1:0]     rsum;
  logic [GAIN_W-1:0]     rnd;
  logic [AXIS_VAL_W-1:0] q;
  logic [AXIS_VAL_W-1:0] wdata;

  always_comb begin
    rsum  = prod + ROUND_HALF;
    rnd   = rsum[PROD_W-1:16];
    q     = (rnd > GAIN_W'(Q15_MAX)) ? Q15_MAX : rnd[AXIS_VAL_W-1:0];
    wdata = neg ? (~q + 1'b1) : q;
  end

  // publish beat contents
  logic                  load;
  logic                  is_last;
  logic [ACW-1:0]        k_next;
  logic [MAX_BUTTONS-1:0] tog_next;

  always_comb begin
    load     = (state == S_LD) && (!out_valid || results.ready);
    k_next   = k + 1'b1;
    is_last  = (ax_seen == '0) || ((ACW + 1)'(k) + 1'b1 == (ACW + 1)'(ax_seen));
    tog_next = tog ^ (live & ~prev);
  end

  // axis memory, one write port and one registered read port
  always_ff @(posedge clk) begin
    if (state == S_WR) begin
      mem[ev_idx] <= wdata;
    end
    if (state == S_RD) begin
      rd_data <= mem[k[AW-1:0]];
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      sticky <= 1'b0;
      dz     <= DZ_RST;
      gain   <= GAIN_RST;
      period <= PERIOD_RST;
      accum  <= ACCUM_RST;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        REG_STICKY: sticky <= cfg.data[0];
        REG_DZ:     dz     <= cfg.data[DZ_W-1:0];
        REG_GAIN:   gain   <= cfg.data[GAIN_W-1:0];
        REG_PERIOD: period <= cfg.data[TICKS_W-1:0];
        REG_ACCUM:  accum  <= cfg.data[TICKS_W-1:0];
        default: ;
      endcase
    end
  end

  // datapath registers without reset
  always_ff @(posedge clk) begin
    if (in_acc && is_axis) begin
      ev_idx <= events.event_number[AW-1:0];
      ev_val <= events.event_value;
    end
    if (state == S_CALC) begin
      mag <= mag_c;
      neg <= neg_c;
    end
    if (state == S_MUL) begin
      prod <= PROD_W'(mag) * PROD_W'(gain);
    end
    if (state == S_RD) begin
      rd_vld <= vld[k[AW-1:0]];
    end
    if (state == S_PUB) begin
      pub_bits <= sticky ? tog_next : live;
    end
    if (load) begin
      out_idx  <= AXIS_IDX_W'(k);
      out_val  <= (ax_seen == '0 || !rd_vld) ? '0 : rd_data;
      out_bits <= BTN_BITS_W'(pub_bits);
      out_bcnt <= BTN_CNT_W'(btn_seen);
      out_acnt <= AXIS_CNT_W'(ax_seen);
      out_last <= is_last;
    end
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      live      <= '0;
      prev      <= '0;
      tog       <= '0;
      btn_seen  <= '0;
      ax_seen   <= '0;
      countdown <= PERIOD_RST;
      gpend     <= 1'b0;
      gath      <= 1'b0;
      vld       <= '0;
      k         <= '0;
      out_valid <= 1'b0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
      end else if (results.ready) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (in_acc) begin
            if (events.req_type == REQ_TICK) begin
              if (countdown <= TICKS_W'(1)) begin
                state <= S_PUB;
              end else begin
                countdown <= countdown - 1'b1;
              end
            end else begin
              live  <= live_next;
              gpend <= gp_next;
              if (is_btn && btn_grow) begin
                btn_seen <= BCW'(9'(events.event_number) + 9'd1);
              end
              if (is_axis && ax_grow) begin
                ax_seen <= ACW'(9'(events.event_number) + 9'd1);
              end
              if (!gp_next) begin
                state <= S_PUB;
              end else begin
                if (!gath) begin
                  gath      <= 1'b1;
                  countdown <= accum;
                end
                state <= is_axis ? S_CALC : S_IDLE;
              end
            end
          end
        end
        S_CALC: state <= S_MUL;
        S_MUL:  state <= S_WR;
        S_WR: begin
          vld[ev_idx] <= 1'b1;
          state       <= S_IDLE;
        end
        S_PUB: begin
          if (sticky) begin
            tog  <= tog_next;
            prev <= live;
          end
          gpend     <= 1'b0;
          gath      <= 1'b0;
          countdown <= period;
          k         <= '0;
          state     <= S_RD;
        end
        S_RD: state <= S_LD;
        S_LD: begin
          if (load) begin
            k     <= k_next;
            state <= is_last ? S_IDLE : S_RD;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign events.ready = (state == S_IDLE);
  assign cfg.ready    = 1'b1;

  assign results.valid        = out_valid;
  assign results.axis_index   = out_idx;
  assign results.axis_value   = out_val;
  assign results.button_bits  = out_bits;
  assign results.button_count = out_bcnt;
  assign results.axis_count   = out_acnt;
  assign results.last         = out_last;

endmodule

`default_nettype wire

@@ sv/jec_checker.sv @@
// port-level checks on the result channel of the joystick event conditioner
`default_nettype none
`include "joystick_event_conditioner_assert.svh"

module jec_checker (
  input wire              clk,
  input wire              rst,
  input wire              out_valid,
  input wire              out_ready,
  input wire [2:0]        axis_index,
  input wire signed [15:0] axis_value,
  input wire [3:0]        axis_count,
  input wire              last
);

  // a stalled beat keeps its contents
  `JEC_ASSERT_NEXT(a_stall_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(axis_index) && $stable(axis_value) && $stable(last), "stalled result beat changed")

  // index lies within the axes seen, or the empty publish shape
  `JEC_ASSERT_NOW(a_index_range, clk, rst, out_valid, (axis_count == 4'd0 && axis_index == 3'd0 && last && axis_value == 16'sd0) || (4'(axis_index) < axis_count), "axis index out of range")

  // last marks exactly the highest seen axis
  `JEC_ASSERT_NOW(a_last_pos, clk, rst, out_valid && axis_count != 4'd0, last == ((4'(axis_index) + 4'd1) == axis_count), "last flag misplaced")

  // saturation is symmetric
  `JEC_ASSERT_NOW(a_no_min, clk, rst, out_valid, axis_value != -16'sd32767 - 16'sd1, "axis value below saturation bound")

endmodule

bind joystick_event_conditioner jec_checker u_jec_checker (
  .clk        (clk),
  .rst        (rst),
  .out_valid  (results.valid),
  .out_ready  (results.ready),
  .axis_index (results.axis_index),
  .axis_value (results.axis_value),
  .axis_count (results.axis_count),
  .last       (results.last)
);

`default_nettype wire

@@ bench/tb_top.sv @@
// testbench for the joystick event conditioner: directed and random events and ticks
`timescale 1ns / 100ps

module tb_top;
  import jec_pkg::*;

  localparam int IDLE_LIMIT = 1000;
  localparam int SETTLE_CYCLES = 20;
  localparam int PHASES = 8;
  localparam int PHASE_ITEMS = 45;

  typedef struct packed {
    logic [AXIS_IDX_W-1:0]        idx;
    logic signed [AXIS_VAL_W-1:0] value;
    logic [BTN_BITS_W-1:0]        buttons;
    logic [BTN_CNT_W-1:0]         nbtn;
    logic [AXIS_CNT_W-1:0]        naxes;
    logic                         last;
  } beat_t;

  // mirrors the conditioner state and holds the beats each publish must produce
  class joy_scoreboard;
    bit                  sticky;
    bit [DZ_W-1:0]       deadzone;
    bit [GAIN_W-1:0]     gain;
    bit [TICKS_W-1:0]    period;
    bit [TICKS_W-1:0]    accum;
    bit [BTN_BITS_W-1:0] live_btn;
    bit [BTN_BITS_W-1:0] prev_btn;
    bit [BTN_BITS_W-1:0] toggled_btn;
    bit [AXIS_VAL_W-1:0] axis_val [MAX_AXES_DEF];
    bit [BTN_CNT_W-1:0]  btn_seen;
    bit [AXIS_CNT_W-1:0] axes_seen;
    bit [TICKS_W-1:0]    countdown;
    bit                  pending_flag;
    bit                  window_open;
    beat_t               pending_beats[$];
    int unsigned         errors;
    int unsigned         items_seen;
    int unsigned         publishes;
    int unsigned         beats_checked;

    function new();
      sticky = 1'b0;
      deadzone = DZ_RST;
      gain = GAIN_RST;
      period = PERIOD_RST;
      accum = ACCUM_RST;
      live_btn = '0;
      prev_btn = '0;
      toggled_btn = '0;
      foreach (axis_val[i]) axis_val[i] = '0;
      btn_seen = '0;
      axes_seen = '0;
      countdown = PERIOD_RST;
      pending_flag = 1'b0;
      window_open = 1'b0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_STICKY: sticky = data[0];
        REG_DZ:     deadzone = data[DZ_W-1:0];
        REG_GAIN:   gain = data[GAIN_W-1:0];
        REG_PERIOD: period = data[TICKS_W-1:0];
        REG_ACCUM:  accum = data[TICKS_W-1:0];
        default: ;
      endcase
    endfunction

    // deadzone removal, gain with rounding, saturation, then negation
    function bit [AXIS_VAL_W-1:0] shape_axis(logic signed [EV_VAL_W-1:0] raw);
      int v;
      int dz;
      int r;
      longint unsigned mag;
      longint unsigned q;
      bit [AXIS_VAL_W-1:0] q16;
      v = int'(raw);
      dz = int'(deadzone);
      if (v < -dz) r = v + dz;
      else if (v > dz) r = v - dz;
      else r = 0;
      mag = 64'((r < 0) ? -r : r);
      q = (mag * gain + 64'd32768) >> 16;
      if (q > 64'd32767) q = 64'd32767;
      q16 = q[AXIS_VAL_W-1:0];
      return (r > 0) ? -q16 : q16;
    endfunction

    function void publish();
      bit [BTN_BITS_W-1:0] bits;
      beat_t b;
      if (sticky) begin
        toggled_btn ^= live_btn & ~prev_btn;
        prev_btn = live_btn;
        bits = toggled_btn;
      end else begin
        bits = live_btn;
      end
      if (axes_seen == 0) begin
        b = '{idx: '0, value: '0, buttons: bits, nbtn: btn_seen, naxes: '0, last: 1'b1};
        pending_beats.push_back(b);
      end else begin
        for (int k = 0; k < axes_seen; k++) begin
          b.idx = k[AXIS_IDX_W-1:0];
          b.value = axis_val[k];
          b.buttons = bits;
          b.nbtn = btn_seen;
          b.naxes = axes_seen;
          b.last = (k + 1 == axes_seen);
          pending_beats.push_back(b);
        end
      end
      publishes++;
      pending_flag = 1'b0;
      window_open = 1'b0;
      countdown = period;
    endfunction

    function void note_event(logic req, logic [EV_TYPE_W-1:0] et, logic [EV_NUM_W-1:0] num,
                             logic signed [EV_VAL_W-1:0] val);
      items_seen++;
      if (req == REQ_TICK) begin
        if (countdown <= 1) publish();
        else countdown--;
      end else begin
        if (et[6:0] == KIND_BUTTON && num < MAX_BUTTONS_DEF) begin
          if (num + 1 > btn_seen) btn_seen = BTN_CNT_W'(num + 1);
          live_btn[num[3:0]] = (val != 0);
          pending_flag = !et[7];
        end else if (et[6:0] == KIND_AXIS && num < MAX_AXES_DEF) begin
          if (num + 1 > axes_seen) axes_seen = AXIS_CNT_W'(num + 1);
          axis_val[num[2:0]] = shape_axis(val);
          pending_flag = 1'b1;
        end
        // anything else leaves the pending flag as it was
        if (!pending_flag) begin
          publish();
        end else if (!window_open) begin
          window_open = 1'b1;
          countdown = accum;
        end
      end
    endfunction

    function void compare_field(string name, int want, int got);
      if (want != got) begin
        errors++;
        $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
      end
    endfunction

    function void check_beat(beat_t got);
      beat_t want;
      if (pending_beats.size() == 0) begin
        errors++;
        $display("%0t: unexpected beat, axis %0d value %0d", $time, got.idx, got.value);
      end else begin
        want = pending_beats.pop_front();
        beats_checked++;
        compare_field("axis_index", want.idx, got.idx);
        compare_field("axis_value", want.value, got.value);
        compare_field("button_bits", want.buttons, got.buttons);
        compare_field("button_count", want.nbtn, got.nbtn);
        compare_field("axis_count", want.naxes, got.naxes);
        compare_field("last", want.last, got.last);
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;

  jec_in_if  ev_if ();
  jec_out_if res_if ();
  jec_cfg_if cfg_if ();

  joystick_event_conditioner u_top (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg_if),
    .events  (ev_if),
    .results (res_if)
  );

  joy_scoreboard sb = new();

  bit tx_steady;
  bit rx_steady;
  int unsigned rx_wait;
  int unsigned idle_cycles;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst && ev_if.valid && ev_if.ready)
      sb.note_event(ev_if.req_type, ev_if.event_type, ev_if.event_number, ev_if.event_value);
  end

  always @(posedge clk) begin
    if (!rst && res_if.valid && res_if.ready)
      sb.check_beat('{idx: res_if.axis_index, value: res_if.axis_value,
                      buttons: res_if.button_bits, nbtn: res_if.button_count,
                      naxes: res_if.axis_count, last: res_if.last});
  end

  // result side: fresh stall drawn after every beat unless rx_steady is set
  always @(posedge clk) begin
    if (rst) begin
      res_if.ready <= 1'b0;
      rx_wait = 0;
    end else if (res_if.valid && res_if.ready) begin
      rx_wait = rx_steady ? 0 : $urandom_range(0, 5);
      res_if.ready <= (rx_wait == 0);
    end else if (rx_wait > 0) begin
      rx_wait--;
      res_if.ready <= (rx_wait == 0);
    end else begin
      res_if.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst || (ev_if.valid && ev_if.ready) || (res_if.valid && res_if.ready) ||
        (cfg_if.valid && cfg_if.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t: timeout, no handshake for %0d cycles", $time, idle_cycles);
      $display("tb: failure");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic send_item(input logic req, input logic [EV_TYPE_W-1:0] et,
                           input logic [EV_NUM_W-1:0] num, input logic [EV_VAL_W-1:0] val);
    int unsigned gap;
    gap = tx_steady ? 0 : $urandom_range(0, 5);
    if (gap != 0) begin
      ev_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    ev_if.valid <= 1'b1;
    ev_if.req_type <= req;
    ev_if.event_type <= et;
    ev_if.event_number <= num;
    ev_if.event_value <= val;
    do @(posedge clk); while (!ev_if.ready);
  endtask

  // hold the sender until every publish is out, then let the block settle
  task automatic drain_results();
    ev_if.valid <= 1'b0;
    // let the scoreboard note the last accepted beat first
    @(posedge clk);
    while (sb.pending_beats.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic load_regs(input logic sticky, input logic [CFG_DATA_W-1:0] dz,
                           input logic [CFG_DATA_W-1:0] gain,
                           input logic [CFG_DATA_W-1:0] period,
                           input logic [CFG_DATA_W-1:0] accum);
    logic [CFG_IDX_W-1:0]  idx [5];
    logic [CFG_DATA_W-1:0] vals [5];
    idx = '{REG_STICKY, REG_DZ, REG_GAIN, REG_PERIOD, REG_ACCUM};
    vals = '{CFG_DATA_W'(sticky), dz, gain, period, accum};
    for (int i = 0; i < 5; i++) begin
      cfg_if.valid <= 1'b1;
      cfg_if.index <= idx[i];
      cfg_if.data <= vals[i];
      do @(posedge clk); while (!cfg_if.ready);
      sb.write_reg(idx[i], vals[i]);
    end
    cfg_if.valid <= 1'b0;
  endtask

  function automatic logic [EV_VAL_W-1:0] pick_axis_value();
    int v;
    case ($urandom_range(0, 3))
      0: v = $urandom_range(0, 65535) - 32768;
      1: begin
        // straddle the deadzone edge on either side
        v = int'(sb.deadzone) + $urandom_range(0, 6) - 3;
        if (v > 32767) v = 32767;
        if ($urandom_range(0, 1)) v = -v;
      end
      2: v = $urandom_range(0, 1) ? 32767 : -32768;
      default: v = $urandom_range(0, 200) - 100;
    endcase
    return v[EV_VAL_W-1:0];
  endfunction

  task automatic send_random();
    int unsigned sel;
    logic init;
    sel = $urandom_range(0, 99);
    init = ($urandom_range(0, 3) == 0);
    if (sel < 40) begin
      send_item(REQ_TICK, '0, '0, '0);
    end else if (sel < 65) begin
      send_item(REQ_EVENT, {init, KIND_BUTTON},
                EV_NUM_W'($urandom_range(0, MAX_BUTTONS_DEF - 1)),
                $urandom_range(0, 1) ? 16'(0) : 16'($urandom));
    end else if (sel < 90) begin
      send_item(REQ_EVENT, {init, KIND_AXIS},
                EV_NUM_W'($urandom_range(0, MAX_AXES_DEF - 1)),
                pick_axis_value());
    end else begin
      send_item(REQ_EVENT, 8'($urandom), 8'($urandom), 16'($urandom));
    end
  endtask

  initial begin
    logic [CFG_DATA_W-1:0] dz, gain, period, accum;
    ev_if.valid <= 1'b0;
    ev_if.req_type <= REQ_EVENT;
    ev_if.event_type <= '0;
    ev_if.event_number <= '0;
    ev_if.event_value <= '0;
    cfg_if.valid <= 1'b0;
    cfg_if.index <= REG_STICKY;
    cfg_if.data <= '0;
    tx_steady = 1'b0;
    rx_steady = 1'b0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // directed part on reset register values
    send_item(REQ_EVENT, {1'b1, KIND_BUTTON}, 8'd0, 16'sd1);
    send_item(REQ_EVENT, {1'b0, KIND_BUTTON}, 8'd15, -16'sd32768);
    send_item(REQ_TICK, '0, '0, '0);
    send_item(REQ_EVENT, {1'b0, KIND_AXIS}, 8'd0, -16'sd32768);
    send_item(REQ_EVENT, {1'b0, KIND_AXIS}, 8'd7, 16'sd32767);
    send_item(REQ_EVENT, {1'b0, KIND_AXIS}, 8'd1, 16'sd1638);
    send_item(REQ_EVENT, {1'b0, KIND_AXIS}, 8'd2, -16'sd1639);
    send_item(REQ_EVENT, {1'b0, KIND_AXIS}, 8'd3, 16'sd0);
    send_item(REQ_TICK, '0, '0, '0);
    // out-of-range numbers and unknown kinds publish at once when no window runs
    send_item(REQ_EVENT, {1'b0, KIND_BUTTON}, 8'd16, 16'sd1);
    send_item(REQ_EVENT, {1'b0, KIND_AXIS}, 8'd8, 16'sd5);
    send_item(REQ_EVENT, 8'h00, 8'hFF, 16'sd32767);
    send_item(REQ_EVENT, 8'hFF, 8'hAA, -16'sd1);
    send_item(REQ_EVENT, {1'b0, KIND_BUTTON}, 8'd5, 16'sd0);
    send_item(REQ_EVENT, 8'h03, 8'h55, 16'sd100);
    send_item(REQ_EVENT, {1'b1, KIND_AXIS}, 8'd4, 16'sd20000);
    send_item(REQ_TICK, '0, '0, '0);
    send_item(REQ_EVENT, {1'b1, KIND_BUTTON}, 8'd15, 16'sd0);
    send_item(REQ_EVENT, 8'h80, 8'h55, 16'sh5555);
    drain_results();

    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: load_regs(1'b1, 20'd0, 20'd65536, 20'd1, 20'd0);
        1: load_regs(1'b0, 20'd29490, 20'd655360, 20'd3, 20'd2);
        2: load_regs(1'b1, CFG_DATA_W'(DZ_RST), CFG_DATA_W'(GAIN_RST), 20'd65535, 20'd65535);
        default: begin
          dz = CFG_DATA_W'($urandom_range(0, 29490));
          gain = CFG_DATA_W'($urandom_range(65536, 655360));
          period = CFG_DATA_W'($urandom_range(1, 8));
          accum = CFG_DATA_W'($urandom_range(0, 4));
          load_regs(1'($urandom_range(0, 1)), dz, gain, period, accum);
        end
      endcase
      tx_steady = (p % 3 == 1);
      rx_steady = (p % 4 == 2);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        send_random();
        if (n == PHASE_ITEMS / 2) drain_results();
      end
      drain_results();
    end

    $display("ran %0d events and ticks over %0d register settings", sb.items_seen, PHASES + 1);
    $display("checked %0d publishes, %0d result beats", sb.publishes, sb.beats_checked);
    if (sb.errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+sv
sv/jec_pkg.sv
sv/jec_if.sv
sv/joystick_event_conditioner.sv
sv/jec_checker.sv
bench/tb_top.sv
